@@ rtl/sad_pkg.sv @@
package sad_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int IDX_IN_W     = 4;
    localparam int STAT_W       = 2;
    localparam int CNT_OUT_W    = 5;
    localparam int DEF_CAPACITY = 16;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_PUSH_MID   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // per-cell load select
    typedef enum logic [1:0] {
        MV_HOLD,
        MV_LEFT,
        MV_RIGHT,
        MV_VALUE
    } sad_mv_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic [DATA_W-1:0]    read_data;
    } sad_rsp_t;

endpackage

@@ rtl/sad_if.sv @@
interface sad_req_if import sad_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic signed [DATA_W-1:0]   value;
    logic [IDX_IN_W-1:0]        index;

    modport source (output valid, opcode, value, index, input ready);
    modport sink   (input valid, opcode, value, index, output ready);
endinterface

interface sad_rsp_if import sad_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STAT_W-1:0]          status;
    logic [CNT_OUT_W-1:0]       count;
    logic signed [DATA_W-1:0]   read_data;

    modport source (output valid, status, count, read_data, input ready);
    modport sink   (input valid, status, count, read_data, output ready);
endinterface

@@ rtl/sad_cell.sv @@
module sad_cell import sad_pkg::*;
(
    input  logic              clk,
    input  sad_mv_t           mv,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    input  logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        case (mv)
            MV_LEFT:  data_next = left;
            MV_RIGHT: data_next = right;
            MV_VALUE: data_next = value;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

@@ rtl/sad_ctrl.sv @@
module sad_ctrl import sad_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic              clk,
    input  logic              rst_n,
    sad_req_if.sink           req,
    sad_rsp_if.source         rsp,
    input  logic [DATA_W-1:0] rd_word,
    output sad_mv_t           mv [CAPACITY]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] pos;
    logic             fire;
    logic             full;
    logic             empty;
    logic             is_push;
    logic             ins;
    logic             del_front;
    logic             rd_ok;
    logic             out_valid_reg;
    sad_rsp_t         rsp_reg;
    sad_rsp_t         rsp_next;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign is_push   = (req.opcode == OP_PUSH_BACK) || (req.opcode == OP_PUSH_FRONT)
                    || (req.opcode == OP_PUSH_MID);
    assign ins       = fire && is_push && !full;
    assign del_front = fire && (req.opcode == OP_POP_FRONT) && !empty;

    always_comb
    begin
        case (req.opcode)
            OP_PUSH_FRONT: pos = '0;
            OP_PUSH_MID:   pos = count_reg >> 1;
            default:       pos = count_reg;
        endcase
    end

    // each cell decides from its own position
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_sel
        always_comb
        begin
            if (ins && (CNT_W'(i) == pos))
                mv[i] = MV_VALUE;
            else if (ins && (CNT_W'(i) > pos) && (CNT_W'(i) <= count_reg))
                mv[i] = MV_LEFT;
            else if (del_front && (CNT_W'(i + 1) < count_reg))
                mv[i] = MV_RIGHT;
            else
                mv[i] = MV_HOLD;
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        rd_ok           = 1'b0;
        rsp_next.status = ST_OK;
        case (req.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_MID:
            begin
                if (full)
                    rsp_next.status = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else
                    count_next = count_reg - 1'b1;
            end
            OP_READ:
            begin
                if (CMP_W'(req.index) < CMP_W'(count_reg))
                    rd_ok = 1'b1;
                else
                    rsp_next.status = ST_RANGE;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.count     = CNT_OUT_W'(count_next);
        rsp_next.read_data = rd_ok ? rd_word : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                count_reg <= count_next;
            if (req.ready)
                out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = rsp_reg.status;
    assign rsp.count     = rsp_reg.count;
    assign rsp.read_data = rsp_reg.read_data;

endmodule

@@ rtl/shifting_array_deque.sv @@
// Bounded deque of signed 32-bit words held in a row of shifting cells.
//
// Channels: req carries one operation per beat (opcode, value, index);
// rsp returns one beat per request (status, count after the operation,
// read_data for an in-range read, else zero).
//
// The response is registered and valid in the cycle after its request.
// Throughput: one request per cycle while rsp is not stalled. Every cell
// loads from its left or right neighbor, the pushed word, or itself in the
// same cycle, so push front, push middle and pop front shift the row as one.
//
// Stall: the response sits in an output register; req.ready stays high
// while that register is empty or being drained, so a stalled receiver
// holds at most one finished beat and then back-pressures req.
//
// Reset: rst_n clears the count and the output valid; the list is empty
// after reset. Cell contents are not cleared and are only read below count.
module shifting_array_deque import sad_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    sad_req_if.sink   req,
    sad_rsp_if.source rsp
);

    sad_mv_t           mv   [CAPACITY];
    logic [DATA_W-1:0] cell_q [CAPACITY];
    logic [DATA_W-1:0] rd_word;

    sad_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_word (rd_word),
        .mv      (mv)
    );

    // cell i takes from i-1 on an insert shift and from i+1 on pop front;
    // the ends are never selected that way, so they see zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        sad_cell u_cell (
            .clk   (clk),
            .mv    (mv[i]),
            .left  (left_w),
            .right (right_w),
            .value (req.value),
            .q     (cell_q[i])
        );
    end

    // read port: the index field reaches the first 16 cells
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if ((i < (1 << IDX_IN_W)) && (req.index == IDX_IN_W'(i)))
                rd_word = cell_q[i];
        end
    end

endmodule

@@ rtl/sad_checker.sv @@
module sad_checker import sad_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [STAT_W-1:0]    rsp_status,
    input logic [CNT_OUT_W-1:0] rsp_count,
    input logic [DATA_W-1:0]    rsp_read_data
);

    // reset empties the output register
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("rsp valid during reset");

    // every accepted request yields a response beat next cycle
    a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted request produced no response");

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_count)
             && $stable(rsp_read_data)))
        else $error("stalled response changed");

    // full refusal only at capacity, empty refusal only at zero
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_count == CNT_OUT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind shifting_array_deque sad_checker #(
    .CAPACITY (CAPACITY)
) u_sad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_count     (rsp.count),
    .rsp_read_data (rsp.read_data)
);

@@ bench/shifting_array_deque_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the shifting-cell deque.
//
// One request beat in, one response beat out. Every request accepted on
// req is run through a behavioral copy of the deque kept here, and the
// response it should produce is queued. Response beats are popped from
// that queue in order and compared field by field.
//
// Stimulus comes in two parts:
//   - a short table of directed operations: refusals on an empty list,
//     extreme words, every opcode including the two spare ones, a fill to
//     capacity with full refusals, and a drain back to empty;
//   - a long random run in bursts that lean toward filling, draining or
//     neither, so the count sweeps the whole range many times over.
// Both channels idle at random, except for one stretch with no idling.
module shifting_array_deque_tb;
    import sad_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DEPTH        = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT     = 17;
    localparam int DRAIN_CYCLES = 8;
    // ~1650 beats in all; this is far beyond the time they take
    localparam int TIMEOUT_NS   = 2_000_000;

    // opcodes the block leaves unused; they must act as a no-op
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    // when set, neither side inserts idle cycles
    bit steady;

    sad_req_if req_bus ();
    sad_rsp_if rsp_bus ();

    shifting_array_deque #(
        .CAPACITY (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral deque: same list, same count, updated per accepted beat.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int                       shadow_len;

    // responses owed by the block, oldest first
    sad_rsp_t pending_rsp_q [$];

    int mismatch_total;
    int beats_total;
    int op_hits     [8];
    int status_hits [4];

    // Applies one operation to the shadow list and returns the response
    // the block should give for it.
    function automatic sad_rsp_t deque_apply(
        input logic [OP_W-1:0]          op,
        input logic signed [DATA_W-1:0] word,
        input logic [IDX_IN_W-1:0]      idx
    );
        sad_rsp_t r;
        int       slot;
        int       k;

        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_MID:
            begin
                if (shadow_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (op == OP_PUSH_BACK)
                        slot = shadow_len;
                    else if (op == OP_PUSH_FRONT)
                        slot = 0;
                    else
                        slot = shadow_len / 2;
                    // open a hole at slot by moving the upper part up
                    for (k = shadow_len; k > slot; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[slot] = word;
                    shadow_len++;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_len--;
            end
            OP_POP_FRONT:
            begin
                if (shadow_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (k = 0; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            OP_READ:
            begin
                // only entries below the count are ever read
                if (idx < shadow_len)
                    r.read_data = shadow_words[idx];
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        r.count = CNT_OUT_W'(shadow_len);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: present one beat, hold it until accepted, then log
    // the response it owes. A pinned response (typed into the directed
    // table) replaces the computed one; the shadow list is still updated.
    // ------------------------------------------------------------------
    task automatic issue_op(
        input logic [OP_W-1:0]          op,
        input logic signed [DATA_W-1:0] word,
        input logic [IDX_IN_W-1:0]      idx,
        input bit                       pinned,
        input logic [STAT_W-1:0]        pin_status,
        input logic [CNT_OUT_W-1:0]     pin_count,
        input logic [DATA_W-1:0]        pin_data
    );
        sad_rsp_t want;

        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.opcode <= op;
        req_bus.value  <= word;
        req_bus.index  <= idx;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);

        // beat taken at this edge
        want = deque_apply(op, word, idx);
        if (pinned)
        begin
            want.status    = pin_status;
            want.count     = pin_count;
            want.read_data = pin_data;
        end
        pending_rsp_q.insert(pending_rsp_q.size(), want);
        beats_total++;
        op_hits[op]++;
        status_hits[want.status]++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, and the in-order check.
    // ------------------------------------------------------------------
    always @(posedge clk)
        rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : rsp_check
        sad_rsp_t want;

        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response beat with nothing outstanding: status %0d count %0d data %h",
                       rsp_bus.status, rsp_bus.count, rsp_bus.read_data);
                mismatch_total++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    mismatch_total++;
                end
                if (rsp_bus.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp_bus.count);
                    mismatch_total++;
                end
                if (rsp_bus.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data,
                           rsp_bus.read_data);
                    mismatch_total++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. A row runs reps times; rows with pinned set carry
    // the response read straight off the spec, the rest use the shadow.
    // ------------------------------------------------------------------
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] word;
        logic [IDX_IN_W-1:0]      idx;
        int                       reps;
        bit                       pinned;
        logic [STAT_W-1:0]        status;
        logic [CNT_OUT_W-1:0]     count;
        logic [DATA_W-1:0]        data;
    } plan_row_t;

    localparam int PLAN_LEN = 25;

    plan_row_t plan [PLAN_LEN] = '{
        // empty list: both pops refused, any read is out of range
        '{OP_POP_BACK,   32'h0000_0000,  4'd0, 1, 1'b1, ST_EMPTY, 5'd0, 32'h0},
        '{OP_POP_FRONT,  32'h0000_0000,  4'd0, 1, 1'b1, ST_EMPTY, 5'd0, 32'h0},
        '{OP_READ,       32'h0000_0000,  4'd0, 1, 1'b1, ST_RANGE, 5'd0, 32'h0},
        // extreme words, one push of each kind: list ends 8000_0000, -1, 7FFF_FFFF
        '{OP_PUSH_BACK,  32'h7FFF_FFFF,  4'd0, 1, 1'b1, ST_OK,    5'd1, 32'h0},
        '{OP_PUSH_FRONT, 32'h8000_0000,  4'd0, 1, 1'b1, ST_OK,    5'd2, 32'h0},
        '{OP_PUSH_MID,   32'hFFFF_FFFF,  4'd0, 1, 1'b1, ST_OK,    5'd3, 32'h0},
        '{OP_READ,       32'h0000_0000,  4'd0, 1, 1'b1, ST_OK,    5'd3, 32'h8000_0000},
        '{OP_READ,       32'h0000_0000,  4'd1, 1, 1'b1, ST_OK,    5'd3, 32'hFFFF_FFFF},
        '{OP_READ,       32'h0000_0000,  4'd2, 1, 1'b1, ST_OK,    5'd3, 32'h7FFF_FFFF},
        // first index at the count, then the top index
        '{OP_READ,       32'h0000_0000,  4'd3, 1, 1'b1, ST_RANGE, 5'd3, 32'h0},
        '{OP_READ,       32'h0000_0000, 4'd15, 1, 1'b1, ST_RANGE, 5'd3, 32'h0},
        // spare opcodes leave everything alone and report zero data
        '{OP_SPARE_A,    32'hFFFF_FFFF, 4'd15, 1, 1'b1, ST_OK,    5'd3, 32'h0},
        '{OP_SPARE_B,    32'hFFFF_FFFF, 4'd15, 1, 1'b1, ST_OK,    5'd3, 32'h0},
        '{OP_POP_FRONT,  32'h0000_0000,  4'd0, 1, 1'b1, ST_OK,    5'd2, 32'h0},
        '{OP_READ,       32'h0000_0000,  4'd0, 1, 1'b1, ST_OK,    5'd2, 32'hFFFF_FFFF},
        '{OP_POP_BACK,   32'h0000_0000,  4'd0, 1, 1'b1, ST_OK,    5'd1, 32'h0},
        // fill to capacity with alternating bit patterns
        '{OP_PUSH_BACK,  32'h5555_5555,  4'd0, 8, 1'b0, ST_OK,    5'd0, 32'h0},
        '{OP_PUSH_MID,   32'hAAAA_AAAA,  4'd0, 7, 1'b0, ST_OK,    5'd0, 32'h0},
        // full: every push kind refused
        '{OP_PUSH_BACK,  32'h0000_0001,  4'd0, 1, 1'b1, ST_FULL,  5'd16, 32'h0},
        '{OP_PUSH_FRONT, 32'h0000_0001,  4'd0, 1, 1'b1, ST_FULL,  5'd16, 32'h0},
        '{OP_PUSH_MID,   32'h0000_0001,  4'd0, 1, 1'b1, ST_FULL,  5'd16, 32'h0},
        '{OP_READ,       32'h0000_0000, 4'd15, 1, 1'b0, ST_OK,    5'd0, 32'h0},
        '{OP_READ,       32'h0000_0000,  4'd8, 1, 1'b0, ST_OK,    5'd0, 32'h0},
        // drain from the front, then one pop too many
        '{OP_POP_FRONT,  32'h0000_0000,  4'd0, 16, 1'b0, ST_OK,   5'd0, 32'h0},
        '{OP_POP_BACK,   32'h0000_0000,  4'd0, 1, 1'b1, ST_EMPTY, 5'd0, 32'h0}
    };

    initial
    begin : stimulus
        int                       row;
        int                       rep;
        int                       done_items;
        int                       mode;
        int                       roll;
        int                       push_cut;
        int                       pop_cut;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] word;
        logic [IDX_IN_W-1:0]      idx;

        rst_n          = 1'b0;
        steady         = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.opcode = OP_PUSH_BACK;
        req_bus.value  = '0;
        req_bus.index  = '0;
        shadow_len     = 0;
        mismatch_total = 0;
        beats_total    = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_LEN; row++)
            for (rep = 0; rep < plan[row].reps; rep++)
                issue_op(plan[row].op, plan[row].word, plan[row].idx, plan[row].pinned,
                         plan[row].status, plan[row].count, plan[row].data);

        // Random run. Bursts lean toward filling, draining or neither so
        // the count keeps crossing empty and full. Spare opcodes are mixed
        // in as noise and not counted.
        done_items = 0;
        mode       = 2;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items % 40 == 0)
                mode = $urandom_range(0, 2);
            steady = (done_items >= 500 && done_items < 800);
            case (mode)
                0:       begin push_cut = 60; pop_cut = 75; end
                1:       begin push_cut = 20; pop_cut = 75; end
                default: begin push_cut = 40; pop_cut = 75; end
            endcase

            // reads mostly land inside the list, some beyond it
            idx = $urandom_range(0, 15);
            if (shadow_len > 0 && $urandom_range(0, 3) != 0)
                idx = $urandom_range(0, shadow_len - 1);

            word = $urandom;
            if ($urandom_range(0, 7) == 0)
                case ($urandom_range(0, 3))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    2:       word = 32'hFFFF_FFFF;
                    default: word = 32'h0000_0000;
                endcase

            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            else if (roll < push_cut)
                case ($urandom_range(0, 2))
                    0:       op = OP_PUSH_BACK;
                    1:       op = OP_PUSH_FRONT;
                    default: op = OP_PUSH_MID;
                endcase
            else if (roll < pop_cut)
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            else
                op = OP_READ;

            issue_op(op, word, idx, 1'b0, ST_OK, '0, '0);
            if (op != OP_SPARE_A && op != OP_SPARE_B)
                done_items++;
        end
        steady = 1'b0;
        req_bus.valid <= 1'b0;

        // let the last responses out, then watch for strays
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d beats: pushes b/f/m %0d/%0d/%0d, pops b/f %0d/%0d, reads %0d, spare %0d",
                 beats_total, op_hits[OP_PUSH_BACK], op_hits[OP_PUSH_FRONT],
                 op_hits[OP_PUSH_MID], op_hits[OP_POP_BACK], op_hits[OP_POP_FRONT],
                 op_hits[OP_READ], op_hits[OP_SPARE_A] + op_hits[OP_SPARE_B]);
        $display("refused on full %0d, refused on empty %0d, reads past the count %0d",
                 status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_RANGE]);
        if (mismatch_total == 0)
            $display("shifting_array_deque_tb: done, clean");
        else
            $display("shifting_array_deque_tb: done, errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("shifting_array_deque_tb: done, errors");
        $finish;
    end

endmodule
